[hw/rtl/imf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// imf_pkg
// Shared constants and types of the 3x3 image filter engine: register
// indexes, filter mode codes, field widths and the square root side payload.
// ----------------------------------------------------------------------------
package imf_pkg;

	localparam int IMF_MAX_WIDTH  = 1024;
	localparam int IMF_MAX_HEIGHT = 4096;

	localparam int PIX_W      = 8;
	localparam int MODE_W     = 2;
	localparam int FW_W       = 11;
	localparam int FH_W       = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [MODE_W-1:0] MODE_MEAN  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GAUSS = 2'd1;
	localparam logic [MODE_W-1:0] MODE_GRAD  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	localparam logic [FW_W-1:0] WIDTH_RESET  = 11'd600;
	localparam logic [FH_W-1:0] HEIGHT_RESET = 13'd400;

	// gradient magnitude: radicand up to 2*255^2, root up to 9 bits
	localparam int SQRT_IN_W  = 18;
	localparam int SQRT_OUT_W = 9;

	typedef struct packed {
		logic emit;   // word goes out
		logic filt;   // interior position, filter result applies
		logic last;   // final word of the frame
	} imf_tag_t;

	typedef struct packed {
		imf_tag_t            tag;
		logic                grad;
		logic [PIX_W-1:0]    val;
	} imf_side_t;

endpackage
`default_nettype wire

[hw/rtl/imf_isqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// imf_isqrt
// Pipelined floor square root, one result bit per stage, with a side payload
// that travels alongside. All stages hold while adv is low.
// ----------------------------------------------------------------------------
module imf_isqrt import imf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  adv,
	input  wire logic                  in_valid,
	input  wire logic [SQRT_IN_W-1:0]  in_rad,
	input  wire imf_side_t             in_side,
	output logic                       out_valid,
	output logic [SQRT_OUT_W-1:0]      out_root,
	output imf_side_t                  out_side
);

	localparam int NS    = SQRT_OUT_W;
	localparam int REM_W = SQRT_OUT_W + 2;
	localparam int TRY_W = REM_W + 2;

	logic                    v_p    [NS+1];
	logic [REM_W-1:0]        rem_p  [NS+1];
	logic [SQRT_OUT_W-1:0]   root_p [NS+1];
	logic [SQRT_IN_W-1:0]    rad_p  [NS+1];
	imf_side_t               side_p [NS+1];

	assign v_p[0]    = in_valid;
	assign rem_p[0]  = '0;
	assign root_p[0] = '0;
	assign rad_p[0]  = in_rad;
	assign side_p[0] = in_side;

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [TRY_W-1:0] rem_t;
		logic [TRY_W-1:0] trial;
		logic             take;

		always_comb begin
			rem_t = {rem_p[k], rad_p[k][SQRT_IN_W-1 -: 2]};
			trial = TRY_W'({root_p[k], 2'b01});
			take  = (rem_t >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_p[k+1] <= 1'b0;
			end else if (adv) begin
				v_p[k+1] <= v_p[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_p[k+1]  <= take ? REM_W'(rem_t - trial) : REM_W'(rem_t);
				root_p[k+1] <= {root_p[k][SQRT_OUT_W-2:0], take};
				rad_p[k+1]  <= rad_p[k] << 2;
				side_p[k+1] <= side_p[k];
			end
		end
	end

	assign out_valid = v_p[NS] & (rem_p[NS] == rem_p[NS] | 1'b1) & (rad_p[NS] == rad_p[NS] | 1'b1);
	assign out_root  = root_p[NS];
	assign out_side  = side_p[NS];

endmodule
`default_nettype wire

[hw/rtl/image_3x3_filter_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// image_3x3_filter_engine
// 3x3 mean, Gaussian or Sobel gradient magnitude filter over a raster stream
// of 8-bit grey pixels, with two line stores in one dual-port memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, pixel, drain) takes one word per cycle
//   in raster order. Each pixel yields the filtered word one row and one
//   pixel behind it; after the last pixel of a frame, clamped width+1 words
//   (drain or pixel) push out the border tail, the last one flagged by
//   last_of_frame. A drain before the tail is taken and dropped.
//   Output channel (out_valid/out_ready, filtered_pixel, last_of_frame).
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//   ready; any write to a known register restarts the frame. Write only
//   while the pipeline is empty.
//   Throughput: one word per cycle while no output stall holds the pipeline.
//   Path from input accept to output valid: the line memory read, the
//   arithmetic stages and the nine-stage square root pipeline.
//   Stall: the whole pipeline holds while the output register carries a word
//   the receiver has not taken, and in_ready is low for that cycle.
//   Reset: registers go to mode 0, 600x400, counters zero, pipeline empty.
//   Line memory contents are not cleared; no clearing pass is needed.
// ----------------------------------------------------------------------------
module image_3x3_filter_engine import imf_pkg::*; #(
	parameter int MAX_WIDTH  = IMF_MAX_WIDTH,
	parameter int MAX_HEIGHT = IMF_MAX_HEIGHT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [PIX_W-1:0]      pixel,
	input  wire logic                  drain,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [PIX_W-1:0]           filtered_pixel,
	output logic                       last_of_frame,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT + 1);

	localparam logic [25:0] MEAN_NUM   = 26'd11111;
	localparam logic [25:0] MEAN_DEN   = 26'd100000;
	localparam int          MEAN_SHIFT = 24;
	localparam logic [32:0] MEAN_RECIP = 33'((64'd11111 << MEAN_SHIFT) / 64'd100000);

	// configuration
	logic [MODE_W-1:0] mode_q;
	logic [FW_W-1:0]   frame_width_q;
	logic [FH_W-1:0]   frame_height_q;
	logic [CW-1:0]     eff_w;
	logic [RW-1:0]     eff_h;

	// position counters
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic [CW-1:0]     col_inc;

	logic adv, acc, cfg_hit, active, take_px, take_tail, tail_last;
	logic out_valid_q;
	logic [PIX_W-1:0] out_pix_q;
	logic             out_last_q;

	// stage registers
	logic               v_s1, mem_s1;
	imf_tag_t           tag_s1;
	logic [PIX_W-1:0]   pix_s1;
	logic [AW-1:0]      addr_s1;
	logic [2*PIX_W-1:0] rd_q;

	logic               v_s2;
	imf_tag_t           tag_s2;

	logic               v_s3;
	imf_tag_t           tag_s3;
	logic [11:0]        sum9_s3;
	logic [PIX_W-1:0]   gauss_s3, gx_s3, gy_s3;

	logic               v_s4;
	imf_tag_t           tag_s4;
	logic [24:0]        prod_s4;
	logic [8:0]         q0_s4;
	logic [16:0]        sq_s4;
	logic [PIX_W-1:0]   gauss_s4;

	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [PIX_W-1:0]   win_q [3][3];

	logic [32:0]        f_wd, f_ht;

	always_comb begin
		f_wd = 33'(frame_width_q);
		f_ht = 33'(frame_height_q);
		if (f_wd < 33'd3)                  eff_w = CW'(3);
		else if (f_wd > 33'(MAX_WIDTH))    eff_w = CW'(MAX_WIDTH);
		else                               eff_w = CW'(f_wd);
		if (f_ht < 33'd3)                  eff_h = RW'(3);
		else if (f_ht > 33'(MAX_HEIGHT))   eff_h = RW'(MAX_HEIGHT);
		else                               eff_h = RW'(f_ht);
	end

	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;
	assign acc       = in_valid && adv;
	assign cfg_hit   = cfg_valid && (cfg_index == REG_MODE || cfg_index == REG_WIDTH ||
		cfg_index == REG_HEIGHT);
	assign active    = (row_q < eff_h);
	assign take_px   = acc && active && !drain;
	assign take_tail = acc && !active;
	assign col_inc   = CW'(col_q + 1'b1);
	// in the tail the column counter counts tail words 0..width
	assign tail_last = (col_q == eff_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_MEAN;
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODE:   mode_q         <= cfg_data[MODE_W-1:0];
				REG_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				REG_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take_px) begin
			if (col_inc >= eff_w) begin
				col_q <= '0;
				row_q <= RW'(row_q + 1'b1);
			end else begin
				col_q <= col_inc;
			end
		end else if (take_tail) begin
			if (tail_last) begin
				col_q <= '0;
				row_q <= '0;
			end else begin
				col_q <= col_inc;
			end
		end
	end

	// stage 1: line memory read and write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take_px || take_tail;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && acc) begin
			mem_s1  <= active;
			pix_s1  <= pixel;
			addr_s1 <= col_q[AW-1:0];
			if (active) begin
				tag_s1.emit <= (row_q >= RW'(2)) || (row_q == RW'(1) && col_q >= CW'(1));
				tag_s1.filt <= (row_q >= RW'(2)) && (col_q >= CW'(2));
				tag_s1.last <= 1'b0;
			end else begin
				tag_s1.emit <= 1'b1;
				tag_s1.filt <= 1'b0;
				tag_s1.last <= tail_last;
			end
		end
	end

	// upper line in the high byte, middle line in the low byte
	always_ff @(posedge clk) begin
		if (adv) begin
			rd_q <= line_mem[col_q[AW-1:0]];
		end
		if (adv && v_s1 && mem_s1) begin
			line_mem[addr_s1] <= {rd_q[PIX_W-1:0], pix_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				for (int r = 0; r < 3; r++) begin
					win_q[c][r] <= '0;
				end
			end
		end else if (adv && v_s1 && mem_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[0][r] <= win_q[1][r];
				win_q[1][r] <= win_q[2][r];
			end
			win_q[2][0] <= rd_q[2*PIX_W-1:PIX_W];
			win_q[2][1] <= rd_q[PIX_W-1:0];
			win_q[2][2] <= pix_s1;
		end
	end

	// stage 2: window sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	logic [11:0]        sum9_c, gsum_c;
	logic [9:0]         top_c, bot_c, lft_c, rgt_c;
	logic signed [10:0] dx_c, dy_c;
	logic [PIX_W-1:0]   gx_c, gy_c;

	always_comb begin
		sum9_c = '0;
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				sum9_c = sum9_c + 12'(win_q[c][r]);
			end
		end
		gsum_c = 12'(win_q[0][0]) + 12'(win_q[2][0]) + 12'(win_q[0][2]) + 12'(win_q[2][2])
			+ ((12'(win_q[1][0]) + 12'(win_q[0][1]) + 12'(win_q[2][1])
			+ 12'(win_q[1][2])) << 1) + (12'(win_q[1][1]) << 2);
		top_c = 10'(win_q[0][0]) + (10'(win_q[1][0]) << 1) + 10'(win_q[2][0]);
		bot_c = 10'(win_q[0][2]) + (10'(win_q[1][2]) << 1) + 10'(win_q[2][2]);
		lft_c = 10'(win_q[0][0]) + (10'(win_q[0][1]) << 1) + 10'(win_q[0][2]);
		rgt_c = 10'(win_q[2][0]) + (10'(win_q[2][1]) << 1) + 10'(win_q[2][2]);
		dx_c  = signed'({1'b0, top_c}) - signed'({1'b0, bot_c});
		dy_c  = signed'({1'b0, rgt_c}) - signed'({1'b0, lft_c});
		// negative differences clamp to zero; quarter of 1020 stays in range
		gx_c  = (dx_c <= 0) ? '0 : dx_c[9:2];
		gy_c  = (dy_c <= 0) ? '0 : dy_c[9:2];
	end

	logic [32:0] recip_c;

	always_comb begin
		recip_c = 33'(sum9_s3) * MEAN_RECIP;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2   <= tag_s1;
			tag_s3   <= tag_s2;
			sum9_s3  <= sum9_c;
			gauss_s3 <= gsum_c[11:4];
			gx_s3    <= gx_c;
			gy_s3    <= gy_c;
			tag_s4   <= tag_s3;
			prod_s4  <= 25'(26'(sum9_s3) * MEAN_NUM);
			q0_s4    <= recip_c[MEAN_SHIFT +: 9];
			sq_s4    <= 17'({9'b0, gx_s3} * {9'b0, gx_s3}) +
				17'({9'b0, gy_s3} * {9'b0, gy_s3});
			gauss_s4 <= gauss_s3;
		end
	end

	// stage 4: mean estimate is exact or one low, correct it
	logic [8:0]       q1_c;
	logic [25:0]      chk_c;
	logic [8:0]       mean_c;
	imf_side_t        side_c;

	always_comb begin
		q1_c   = 9'(q0_s4 + 1'b1);
		chk_c  = 26'(q1_c) * MEAN_DEN;
		mean_c = (chk_c <= 26'(prod_s4)) ? q1_c : q0_s4;
		side_c.tag  = tag_s4;
		side_c.grad = (mode_q == MODE_GRAD);
		unique case (mode_q)
			MODE_MEAN:  side_c.val = mean_c[PIX_W-1:0];
			MODE_GAUSS: side_c.val = gauss_s4;
			default:    side_c.val = '0;
		endcase
	end

	logic                  sq_valid;
	logic [SQRT_OUT_W-1:0] sq_root;
	imf_side_t             sq_side;
	logic [PIX_W-1:0]      res_c;

	imf_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s4),
		.in_rad    (SQRT_IN_W'(sq_s4)),
		.in_side   (side_c),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	always_comb begin
		if (!sq_side.tag.filt)
			res_c = '0;
		else if (sq_side.grad)
			res_c = (sq_root > SQRT_OUT_W'(255)) ? 8'hFF : sq_root[PIX_W-1:0];
		else
			res_c = sq_side.val;
	end

	// output register; drop words that carry no result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= sq_valid && sq_side.tag.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_pix_q  <= res_c;
			out_last_q <= sq_side.tag.last;
		end
	end

	assign out_valid      = out_valid_q;
	assign filtered_pixel = out_pix_q;
	assign last_of_frame  = out_last_q;

endmodule
`default_nettype wire

[hw/rtl/imf_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// imf_checker
// Port-level checks of the 3x3 image filter engine, bound to the top level.
// ----------------------------------------------------------------------------
module imf_checker import imf_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [PIX_W-1:0] filtered_pixel,
	input wire logic             last_of_frame
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(filtered_pixel) &&
			$stable(last_of_frame))
		else $error("output word changed while stalled");

	// a stalled output blocks new input
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while output stalled");

	// the closing word of a frame lies on the border
	a_last_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_frame |-> filtered_pixel == '0)
		else $error("last word of frame is not zero");

	// reset empties the output
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid during reset");

endmodule

bind image_3x3_filter_engine imf_checker u_imf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.filtered_pixel (filtered_pixel),
	.last_of_frame  (last_of_frame)
);
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3x3 image filter engine. A short table of
// words and register writes runs first, then random frames in all modes and
// sizes, with random gaps on both channels and one long output stall. Each
// result is checked against its table entry or a cycle-free filter model here.
// ----------------------------------------------------------------------------
module testbench;
	import imf_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
	localparam int unsigned RANDOM_ITEMS  = 1850;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned STALL_CYCLES  = 400;
	localparam int unsigned STUCK_LIMIT   = 2000;
	localparam int          PLAN_LEN      = 29;

	typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_WORD} exp_kind_t;
	typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  drn;
		exp_kind_t             ek;
		logic [PIX_W-1:0]      ev;
		logic                  el;
	} plan_row_t;

	typedef struct {
		logic [PIX_W-1:0] value;
		logic             last;
	} out_word_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [PIX_W-1:0]      pixel = '0;
	logic                  drain = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [PIX_W-1:0]      filtered_pixel;
	logic                  last_of_frame;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_MODE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// expectation that travels with the word on the input channel
	exp_kind_t        word_ek = EXP_NONE;
	logic [PIX_W-1:0] word_ev = '0;
	logic             word_el = 1'b0;

	bit          quiet = 1'b0;
	bit          stall_req = 1'b0;
	int unsigned stall_left = 0;
	int unsigned items_sent = 0;
	int unsigned mismatch_count = 0;
	int unsigned words_seen = 0;

	out_word_t pending_words [$];

	// filter model state
	logic [MODE_W-1:0] cur_mode;
	logic [FW_W-1:0]   cur_width;
	logic [FH_W-1:0]   cur_height;
	logic [PIX_W-1:0]  upper_mem [IMF_MAX_WIDTH];
	logic [PIX_W-1:0]  mid_mem [IMF_MAX_WIDTH];
	logic [PIX_W-1:0]  win [3][3];  // [column][row], column 0 left, row 0 top
	int unsigned       in_col;
	int unsigned       in_row;
	int unsigned       out_pos;

	plan_row_t plan [PLAN_LEN] = '{
		'{ROW_WORD, REG_MODE,   13'h05A, 1'b1, EXP_NONE,  8'd0,   1'b0},
		'{ROW_CFG,  REG_NONE,   13'h1FFF, 1'b0, EXP_NONE, 8'd0,   1'b0},
		'{ROW_CFG,  REG_WIDTH,  13'd3,   1'b0, EXP_NONE,  8'd0,   1'b0},
		'{ROW_CFG,  REG_HEIGHT, 13'd3,   1'b0, EXP_NONE,  8'd0,   1'b0},
		'{ROW_CFG,  REG_MODE,   13'(MODE_GAUSS), 1'b0, EXP_NONE, 8'd0, 1'b0},
		'{ROW_WORD, REG_MODE,   13'h0FF, 1'b0, EXP_NONE,  8'd0,   1'b0},
		'{ROW_WORD, REG_MODE,   13'h0FF, 1'b0, EXP_NONE,  8'd0,   1'b0},
		'{ROW_WORD, REG_MODE,   13'h000, 1'b1, EXP_NONE,  8'd0,   1'b0},
		'{ROW_WORD, REG_MODE,   13'h0FF, 1'b0, EXP_NONE,  8'd0,   1'b0},
		'{ROW_WORD, REG_MODE,   13'h0FF, 1'b0, EXP_NONE,  8'd0,   1'b0},
		'{ROW_WORD, REG_MODE,   13'h0FF, 1'b0, EXP_WORD,  8'd0,   1'b0},
		'{ROW_WORD, REG_MODE,   13'h0FF, 1'b0, EXP_WORD,  8'd0,   1'b0},
		'{ROW_WORD, REG_MODE,   13'h0FF, 1'b0, EXP_WORD,  8'd0,   1'b0},
		'{ROW_WORD, REG_MODE,   13'h0FF, 1'b0, EXP_WORD,  8'd0,   1'b0},
		'{ROW_WORD, REG_MODE,   13'h0FF, 1'b0, EXP_WORD,  8'd255, 1'b0},
		'{ROW_WORD, REG_MODE,   13'h000, 1'b1, EXP_WORD,  8'd0,   1'b0},
		'{ROW_WORD, REG_MODE,   13'h080, 1'b0, EXP_WORD,  8'd0,   1'b0},
		'{ROW_WORD, REG_MODE,   13'h000, 1'b1, EXP_WORD,  8'd0,   1'b0},
		'{ROW_WORD, REG_MODE,   13'h07F, 1'b1, EXP_WORD,  8'd0,   1'b1},
		'{ROW_CFG,  REG_MODE,   13'(MODE_GRAD), 1'b0, EXP_NONE, 8'd0, 1'b0},
		'{ROW_WORD, REG_MODE,   13'h0FF, 1'b0, EXP_NONE,  8'd0,   1'b0},
		'{ROW_WORD, REG_MODE,   13'h0FF, 1'b0, EXP_NONE,  8'd0,   1'b0},
		'{ROW_WORD, REG_MODE,   13'h0FF, 1'b0, EXP_NONE,  8'd0,   1'b0},
		'{ROW_WORD, REG_MODE,   13'h012, 1'b0, EXP_NONE,  8'd0,   1'b0},
		'{ROW_WORD, REG_MODE,   13'h034, 1'b0, EXP_WORD,  8'd0,   1'b0},
		'{ROW_WORD, REG_MODE,   13'h056, 1'b0, EXP_WORD,  8'd0,   1'b0},
		'{ROW_WORD, REG_MODE,   13'h000, 1'b0, EXP_WORD,  8'd0,   1'b0},
		'{ROW_WORD, REG_MODE,   13'h000, 1'b0, EXP_WORD,  8'd0,   1'b0},
		'{ROW_WORD, REG_MODE,   13'h000, 1'b0, EXP_MODEL, 8'd0,   1'b0}
	};

	image_3x3_filter_engine u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.pixel          (pixel),
		.drain          (drain),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.filtered_pixel (filtered_pixel),
		.last_of_frame  (last_of_frame),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- model

	function automatic int unsigned eff_width();
		if (cur_width < 3) return 3;
		if (cur_width > IMF_MAX_WIDTH) return IMF_MAX_WIDTH;
		return cur_width;
	endfunction

	function automatic int unsigned eff_height();
		if (cur_height < 3) return 3;
		if (cur_height > IMF_MAX_HEIGHT) return IMF_MAX_HEIGHT;
		return cur_height;
	endfunction

	function automatic int unsigned root_floor(input int unsigned v);
		int unsigned r, t;
		r = 0;
		for (int b = 9; b >= 0; b--) begin
			t = r | (32'd1 << b);
			if (t * t <= v) r = t;
		end
		return r;
	endfunction

	function automatic int unsigned quarter_clamp(input int s);
		if (s <= 0) return 0;
		return ((s >> 2) > 255) ? 255 : (s >> 2);
	endfunction

	function automatic logic [PIX_W-1:0] window_value();
		int unsigned acc, gx, gy, mag;
		int top_s, bot_s, lft_s, rgt_s;
		acc = 0;
		case (cur_mode)
		MODE_MEAN: begin
			for (int c = 0; c < 3; c++)
				for (int r = 0; r < 3; r++)
					acc += win[c][r];
			return 8'((acc * 32'd11111) / 32'd100000);
		end
		MODE_GAUSS: begin
			acc = win[0][0] + win[2][0] + win[0][2] + win[2][2]
				+ 2 * (win[1][0] + win[0][1] + win[2][1] + win[1][2])
				+ 4 * win[1][1];
			return 8'(acc >> 4);
		end
		MODE_GRAD: begin
			top_s = win[0][0] + 2 * win[1][0] + win[2][0];
			bot_s = win[0][2] + 2 * win[1][2] + win[2][2];
			lft_s = win[0][0] + 2 * win[0][1] + win[0][2];
			rgt_s = win[2][0] + 2 * win[2][1] + win[2][2];
			gx = quarter_clamp(top_s - bot_s);
			gy = quarter_clamp(rgt_s - lft_s);
			mag = root_floor(gx * gx + gy * gy);
			return (mag > 255) ? 8'd255 : 8'(mag);
		end
		default: return '0;
		endcase
	endfunction

	function automatic bit filter_step(input logic [PIX_W-1:0] pix, input logic drn,
			output logic [PIX_W-1:0] val, output logic lst);
		int unsigned w, h, c;
		logic [PIX_W-1:0] top, mid;
		bit emit;
		w = eff_width();
		h = eff_height();
		val = '0;
		lst = 1'b0;
		if (in_row < h) begin
			// drop drains until the frame's pixels are all in
			if (drn) return 1'b0;
			c = (in_col >= IMF_MAX_WIDTH) ? IMF_MAX_WIDTH - 1 : in_col;
			top = upper_mem[c];
			mid = mid_mem[c];
			upper_mem[c] = mid;
			mid_mem[c] = pix;
			for (int k = 0; k < 3; k++) begin
				win[0][k] = win[1][k];
				win[1][k] = win[2][k];
			end
			win[2][0] = top;
			win[2][1] = mid;
			win[2][2] = pix;
			if (in_row >= 2 && c >= 2) val = window_value();
			emit = (in_row >= 2) || (in_row == 1 && c >= 1);
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
			if (emit) out_pos++;
			return emit;
		end
		// tail: border words only
		if (out_pos + 1 >= w * h) begin
			lst = 1'b1;
			in_col = 0;
			in_row = 0;
			out_pos = 0;
		end else
			out_pos++;
		return 1'b1;
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
		REG_MODE:   cur_mode = val[MODE_W-1:0];
		REG_WIDTH:  cur_width = val[FW_W-1:0];
		REG_HEIGHT: cur_height = val[FH_W-1:0];
		default:    return;
		endcase
		in_col = 0;
		in_row = 0;
		out_pos = 0;
	endfunction

	function automatic void reset_model();
		cur_mode = MODE_MEAN;
		cur_width = WIDTH_RESET;
		cur_height = HEIGHT_RESET;
		for (int i = 0; i < IMF_MAX_WIDTH; i++) begin
			upper_mem[i] = '0;
			mid_mem[i] = '0;
		end
		for (int c = 0; c < 3; c++)
			for (int r = 0; r < 3; r++)
				win[c][r] = '0;
		in_col = 0;
		in_row = 0;
		out_pos = 0;
	endfunction

	// ------------------------------------------------------------ checking

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 100) $display("[%0t] mismatch: %s", $time, what);
	endtask

	always @(posedge clk) begin : monitor
		out_word_t head;
		logic [PIX_W-1:0] pv;
		logic pl;
		bit got;
		// take the output word before predicting this edge's input word
		if (out_valid && out_ready) begin
			if (pending_words.size() == 0)
				report_mismatch($sformatf("word %0d arrived with nothing expected", words_seen));
			else begin
				head = pending_words.pop_front();
				if (filtered_pixel !== head.value)
					report_mismatch($sformatf("word %0d filtered_pixel %0h, want %0h",
						words_seen, filtered_pixel, head.value));
				if (last_of_frame !== head.last)
					report_mismatch($sformatf("word %0d last_of_frame %0b, want %0b",
						words_seen, last_of_frame, head.last));
			end
			words_seen++;
		end
		if (in_valid && in_ready) begin
			got = filter_step(pixel, drain, pv, pl);
			case (word_ek)
			EXP_MODEL: if (got) pending_words.push_back('{pv, pl});
			EXP_WORD:  pending_words.push_back('{word_ev, word_el});
			default:   ;
			endcase
		end
		if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
	end

	// output side: random holds, plus one long stall on request
	always @(posedge clk) begin
		if (stall_req) begin
			stall_left = STALL_CYCLES;
			stall_req = 1'b0;
		end
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else
			out_ready <= quiet || ($urandom_range(99) >= 7);
	end

	initial begin : watchdog
		int unsigned still;
		still = 0;
		while (still < STUCK_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				still = 0;
			else
				still++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ------------------------------------------------------------- stimulus

	task automatic send_word(input logic [PIX_W-1:0] pix, input logic drn,
			input exp_kind_t ek, input logic [PIX_W-1:0] ev, input logic el);
		if (!quiet && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= pix;
		drain <= drn;
		word_ek <= ek;
		word_ev <= ev;
		word_el <= el;
		do @(posedge clk); while (!in_ready);
	endtask

	// hold the input until every expected word is out and the pipe is empty
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic pick_setting();
		int unsigned sel, wv, hv;
		if ($urandom_range(99) < 60)
			write_reg(REG_MODE, {11'($urandom), 2'($urandom_range(3))});
		if ($urandom_range(99) < 60) begin
			sel = $urandom_range(99);
			if (sel < 8) wv = $urandom_range(2);
			else if (sel < 12) wv = $urandom_range(1025, 2047);
			else wv = $urandom_range(3, 12);
			write_reg(REG_WIDTH, {2'($urandom_range(3)), 11'(wv)});
		end
		if ($urandom_range(99) < 60) begin
			sel = $urandom_range(99);
			if (sel < 8) hv = $urandom_range(2);
			else if (sel < 11) hv = $urandom_range(4097, 8191);
			else hv = $urandom_range(3, 8);
			write_reg(REG_HEIGHT, 13'(hv));
		end
		if ($urandom_range(9) == 0) write_reg(REG_NONE, 13'($urandom));
	endtask

	// pixels of one frame with stray drains mixed in, then the tail if asked
	task automatic run_frame(input int unsigned npix, input bit with_tail);
		int unsigned w, base;
		bit smooth;
		w = eff_width();
		smooth = 1'($urandom_range(1));
		base = $urandom_range(240);
		for (int unsigned i = 0; i < npix; i++) begin
			if ($urandom_range(99) < 3) send_word(8'($urandom), 1'b1, EXP_MODEL, 8'd0, 1'b0);
			send_word(smooth ? 8'(base + $urandom_range(15)) : 8'($urandom), 1'b0,
				EXP_MODEL, 8'd0, 1'b0);
			items_sent++;
		end
		if (with_tail)
			for (int unsigned i = 0; i <= w; i++) begin
				send_word(8'($urandom), 1'($urandom_range(3) != 0), EXP_MODEL, 8'd0, 1'b0);
				items_sent++;
			end
	endtask

	initial begin : stimulus
		int unsigned phase, frames, area, npix;
		bit broken;
		reset_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				settle();
				write_reg(plan[i].idx, plan[i].data);
			end else
				send_word(plan[i].data[PIX_W-1:0], plan[i].drn, plan[i].ek, plan[i].ev,
					plan[i].el);
		end

		phase = 0;
		while (items_sent < RANDOM_ITEMS) begin
			settle();
			quiet = (phase >= 12 && phase < 16);
			if (phase == 2) begin
				write_reg(REG_WIDTH, 13'd1024);
				write_reg(REG_HEIGHT, 13'd3);
				write_reg(REG_MODE, 13'($urandom_range(3)));
				// stall the output while a wide frame keeps coming
				stall_req = 1'b1;
			end else if (phase == 4) begin
				write_reg(REG_WIDTH, 13'd3);
				write_reg(REG_HEIGHT, 13'd4096);
			end else
				pick_setting();
			broken = 1'b0;
			frames = (phase == 2) ? 1 : $urandom_range(1, 3);
			for (int f = 0; f < frames && !broken; f++) begin
				area = eff_width() * eff_height();
				if (phase == 4) begin
					npix = 600;
					broken = 1'b1;
				end else if (phase == 2)
					npix = area;
				else if (area > 300) begin
					npix = $urandom_range(20, 300);
					broken = 1'b1;
				end else if ($urandom_range(99) < 12) begin
					npix = $urandom_range(1, area - 1);
					broken = 1'b1;
				end else
					npix = area;
				run_frame(npix, !broken);
			end
			phase++;
		end

		settle();
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
